// File: hw/rtl/torus_grid_wavefront_labeler_assert.svh
// Assertion shorthands for the labeler checker.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef TORUS_GRID_WAVEFRONT_LABELER_ASSERT_SVH
`define TORUS_GRID_WAVEFRONT_LABELER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define TGWL_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define TGWL_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/tgwl_pkg.sv
package tgwl_pkg;

  localparam int COORD_W     = 6;
  localparam int IN_COORD_W  = 8;
  localparam int WV_W        = 16;
  localparam int OUT_LABEL_W = 16;
  localparam int CFG_W       = 6;

  typedef logic [2:0] op_t;
  localparam op_t OP_BLOCK  = 3'd0;
  localparam op_t OP_WRITE  = 3'd1;
  localparam op_t OP_CHECK  = 3'd2;
  localparam op_t OP_EXPAND = 3'd3;
  localparam op_t OP_PRED   = 3'd4;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK       = 2'd0;
  localparam status_t ST_OCCUPIED = 2'd1;
  localparam status_t ST_RANGE    = 2'd2;

  typedef logic cfg_idx_t;
  localparam cfg_idx_t CFG_EDGE_X = 1'b0;
  localparam cfg_idx_t CFG_EDGE_Y = 1'b1;

  // neighbour order: east, south, west, north
  typedef logic [1:0] dir_t;
  localparam dir_t DIR_E = 2'd0;
  localparam dir_t DIR_S = 2'd1;
  localparam dir_t DIR_W = 2'd2;
  localparam dir_t DIR_N = 2'd3;

endpackage

// File: hw/rtl/torus_grid_wavefront_labeler.sv
// Wavefront labeler on a wrapping grid (breadth-first maze expansion).
// Input channel: an item (in_op, in_x, in_y, in_write_value) is taken at a
//   rising edge where start is high and busy is low.
// Result channel: each result sits on the out_ ports for one cycle with
//   out_valid high; out_last marks the final result of an item. There is no
//   backpressure: the receiver must take every result as it comes.
// Config: cfg_we / cfg_index / cfg_data write edge_x (0) or edge_y (1) in
//   any cycle; change them only while the block is idle.
// Per item, from accept to its last result:
//   undefined op or out-of-range cell: result shows the next cycle,
//     busy stays low;
//   block / write / check: one read, then a write-back for block and write;
//   expand / predecessor: the five reads (centre plus four neighbours)
//     share the single read port of the cell memory; writes and results
//     then go out one per cycle.
// Reset: clears the edges to 63, then runs a clearing pass over the
//   GRID_DIM*GRID_DIM (4096 by default) cell memory entries, one entry a
//   cycle, with busy held high. Config writes are taken during the pass.
module torus_grid_wavefront_labeler #(
  parameter int GRID_DIM   = 64,
  parameter int LABEL_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  tgwl_pkg::op_t                       in_op,
  input  logic signed [tgwl_pkg::IN_COORD_W-1:0] in_x,
  input  logic signed [tgwl_pkg::IN_COORD_W-1:0] in_y,
  input  logic [tgwl_pkg::WV_W-1:0]           in_write_value,
  output logic                                out_valid,
  output tgwl_pkg::status_t                   out_status,
  output logic                                out_found,
  output logic [tgwl_pkg::COORD_W-1:0]        out_nx,
  output logic [tgwl_pkg::COORD_W-1:0]        out_ny,
  output logic [tgwl_pkg::OUT_LABEL_W-1:0]    out_label,
  output logic                                out_last,
  input  logic                                cfg_we,
  input  tgwl_pkg::cfg_idx_t                  cfg_index,
  input  logic [tgwl_pkg::CFG_W-1:0]          cfg_data
);

  import tgwl_pkg::*;

  localparam int CELLS  = GRID_DIM * GRID_DIM;
  localparam int AW     = $clog2(CELLS);
  localparam int MEM_W  = LABEL_BITS + 1;
  // highest coordinate the grid can hold given the 6-bit edge registers
  localparam int MAX_C  = (GRID_DIM - 1 > (1 << COORD_W) - 1) ?
                          (1 << COORD_W) - 1 : GRID_DIM - 1;
  localparam logic [COORD_W-1:0]    MAX_COORD = COORD_W'(MAX_C);
  localparam logic [LABEL_BITS-1:0] LABEL_MAX = '1;
  localparam logic [AW-1:0]         LAST_CELL = AW'(CELLS - 1);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_DRAIN,
    S_SINGLE,
    S_EMIT
  } state_t;

  function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] px,
                                            input logic [COORD_W-1:0] py);
    logic [31:0] lin;
    lin = 32'(px) * 32'(GRID_DIM) + 32'(py);
    return lin[AW-1:0];
  endfunction

  state_t                  state_r;
  logic                    busy_r;
  logic [COORD_W-1:0]      edge_x_r, edge_y_r;
  logic [AW-1:0]           clr_addr_r;
  op_t                     op_r;
  logic [COORD_W-1:0]      cx_r, cy_r;
  logic [LABEL_BITS-1:0]   wv_r;
  logic [COORD_W-1:0]      nx_r [4];
  logic [COORD_W-1:0]      ny_r [4];
  logic [2:0]              rd_idx_r;    // 0 = centre, 1..4 = E,S,W,N
  logic [LABEL_BITS-1:0]   centre_r;
  logic                    cblk_r;
  logic [3:0]              hit_r;

  logic                    out_valid_r, out_found_r, out_last_r;
  status_t                 out_status_r;
  logic [COORD_W-1:0]      out_nx_r, out_ny_r;
  logic [OUT_LABEL_W-1:0]  out_label_r;

  // accept-side decode
  logic [COORD_W-1:0]      ex, ey, ix, iy;
  logic                    inr;

  // memory side
  logic                    mem_we;
  logic [AW-1:0]           mem_waddr, cell_addr;
  logic [MEM_W-1:0]        mem_wdata, mem_rdata;
  logic                    rd_blk;
  logic [LABEL_BITS-1:0]   rd_label;

  dir_t                    pick, dir_sel;
  logic                    use_centre;
  logic [COORD_W-1:0]      sel_x, sel_y;
  logic                    hit_now, last_hit;
  logic [3:0]              hit_rest;
  logic [LABEL_BITS-1:0]   newval, report_label;

  // An edge above the grid acts as the grid's last row/column.
  assign ex  = (edge_x_r > MAX_COORD) ? MAX_COORD : edge_x_r;
  assign ey  = (edge_y_r > MAX_COORD) ? MAX_COORD : edge_y_r;
  assign ix  = in_x[COORD_W-1:0];
  assign iy  = in_y[COORD_W-1:0];
  assign inr = !in_x[IN_COORD_W-1] && !in_y[IN_COORD_W-1] &&
               (in_x[IN_COORD_W-2:0] <= (IN_COORD_W-1)'(ex)) &&
               (in_y[IN_COORD_W-2:0] <= (IN_COORD_W-1)'(ey));

  // lowest pending hit goes out first
  always_comb begin
    priority if (hit_r[0]) begin
      pick = DIR_E;
    end else if (hit_r[1]) begin
      pick = DIR_S;
    end else if (hit_r[2]) begin
      pick = DIR_W;
    end else begin
      pick = DIR_N;
    end
  end

  assign hit_rest = hit_r & ~(4'b0001 << pick);
  assign last_hit = (hit_rest == 4'b0000);

  // One coordinate pair drives the cell address: the centre, or the
  // neighbour being read (READ) or written back (EMIT).
  assign dir_sel    = (state_r == S_EMIT) ? pick : dir_t'(rd_idx_r - 3'd1);
  assign use_centre = ((state_r == S_READ) && (rd_idx_r == 3'd0)) ||
                      (state_r == S_SINGLE);
  assign sel_x      = use_centre ? cx_r : nx_r[dir_sel];
  assign sel_y      = use_centre ? cy_r : ny_r[dir_sel];
  assign cell_addr  = addr_of(sel_x, sel_y);

  assign rd_blk   = mem_rdata[LABEL_BITS];
  assign rd_label = mem_rdata[LABEL_BITS-1:0];

  assign newval       = (centre_r == LABEL_MAX) ? centre_r : centre_r + LABEL_BITS'(1);
  assign report_label = (op_r == OP_EXPAND) ? newval : centre_r - LABEL_BITS'(1);

  // neighbour test on the word just read
  assign hit_now = !rd_blk &&
                   ((op_r == OP_EXPAND) ? (rd_label == '0) :
                    ((centre_r != '0) && (rd_label == centre_r - LABEL_BITS'(1))));

  // Writes only happen after all reads of an item, so no read ever races a
  // write to the same entry; no forwarding needed.
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = cell_addr;
    mem_wdata = '0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
      end
      S_SINGLE: begin
        if (op_r == OP_BLOCK) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b1, rd_label};
        end else if (op_r == OP_WRITE) begin
          mem_we    = 1'b1;
          mem_wdata = {rd_blk, wv_r};
        end
      end
      S_EMIT: begin
        if ((op_r == OP_EXPAND) && (hit_r != 4'b0000)) begin
          mem_we    = 1'b1;
          mem_wdata = {1'b0, newval};
        end
      end
      default: begin
      end
    endcase
  end

  tgwl_ram #(
    .WIDTH (MEM_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (cell_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      busy_r      <= 1'b1;
      clr_addr_r  <= '0;
      edge_x_r    <= '1;
      edge_y_r    <= '1;
      rd_idx_r    <= '0;
      hit_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_EDGE_X: edge_x_r <= cfg_data;
          CFG_EDGE_Y: edge_y_r <= cfg_data;
        endcase
      end

      unique case (state_r)
        S_CLEAR: begin
          clr_addr_r <= clr_addr_r + AW'(1);
          if (clr_addr_r == LAST_CELL) begin
            state_r <= S_IDLE;
            busy_r  <= 1'b0;
          end
        end

        S_IDLE: begin
          if (start) begin
            op_r     <= in_op;
            cx_r     <= ix;
            cy_r     <= iy;
            wv_r     <= LABEL_BITS'(in_write_value);
            // wrapped neighbours, E S W N
            nx_r[DIR_E] <= (ix == ex) ? '0 : ix + COORD_W'(1);
            ny_r[DIR_E] <= iy;
            nx_r[DIR_S] <= ix;
            ny_r[DIR_S] <= (iy == '0) ? ey : iy - COORD_W'(1);
            nx_r[DIR_W] <= (ix == '0) ? ex : ix - COORD_W'(1);
            ny_r[DIR_W] <= iy;
            nx_r[DIR_N] <= ix;
            ny_r[DIR_N] <= (iy == ey) ? '0 : iy + COORD_W'(1);
            rd_idx_r <= '0;
            hit_r    <= '0;
            if (in_op > OP_PRED) begin
              // undefined op: answered at once, all zero but out_last
              out_valid_r  <= 1'b1;
              out_status_r <= ST_OK;
              out_found_r  <= 1'b0;
              out_nx_r     <= '0;
              out_ny_r     <= '0;
              out_label_r  <= '0;
              out_last_r   <= 1'b1;
            end else if (!inr) begin
              out_valid_r  <= 1'b1;
              out_status_r <= ST_RANGE;
              out_found_r  <= 1'b0;
              out_nx_r     <= '0;
              out_ny_r     <= '0;
              out_label_r  <= '0;
              out_last_r   <= 1'b1;
            end else begin
              state_r <= S_READ;
              busy_r  <= 1'b1;
            end
          end
        end

        S_READ: begin
          rd_idx_r <= rd_idx_r + 3'd1;
          if (rd_idx_r == 3'd1) begin
            centre_r <= rd_label;
            cblk_r   <= rd_blk;
          end
          if (rd_idx_r >= 3'd2) begin
            hit_r[dir_t'(rd_idx_r - 3'd2)] <= hit_now;
          end
          if ((rd_idx_r == 3'd0) && (op_r <= OP_CHECK)) begin
            state_r <= S_SINGLE;
          end else if (rd_idx_r == 3'd4) begin
            state_r <= S_DRAIN;
          end
        end

        S_DRAIN: begin
          hit_r[DIR_N] <= hit_now;
          state_r      <= S_EMIT;
        end

        S_SINGLE: begin
          out_valid_r  <= 1'b1;
          out_status_r <= rd_blk ? ST_OCCUPIED : ST_OK;
          out_found_r  <= 1'b0;
          out_nx_r     <= '0;
          out_ny_r     <= '0;
          out_label_r  <= OUT_LABEL_W'((op_r == OP_WRITE) ? wv_r : rd_label);
          out_last_r   <= 1'b1;
          state_r      <= S_IDLE;
          busy_r       <= 1'b0;
        end

        S_EMIT: begin
          out_valid_r  <= 1'b1;
          out_status_r <= cblk_r ? ST_OCCUPIED : ST_OK;
          if (hit_r == 4'b0000) begin
            out_found_r <= 1'b0;
            out_nx_r    <= '0;
            out_ny_r    <= '0;
            out_label_r <= '0;
            out_last_r  <= 1'b1;
            state_r     <= S_IDLE;
            busy_r      <= 1'b0;
          end else begin
            out_found_r <= 1'b1;
            out_nx_r    <= nx_r[pick];
            out_ny_r    <= ny_r[pick];
            out_label_r <= OUT_LABEL_W'(report_label);
            out_last_r  <= last_hit;
            hit_r       <= hit_rest;
            if (last_hit) begin
              state_r <= S_IDLE;
              busy_r  <= 1'b0;
            end
          end
        end

        default: begin
          state_r <= S_IDLE;
          busy_r  <= 1'b0;
        end
      endcase
    end
  end

  assign busy       = busy_r;
  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_found  = out_found_r;
  assign out_nx     = out_nx_r;
  assign out_ny     = out_ny_r;
  assign out_label  = out_label_r;
  assign out_last   = out_last_r;

endmodule

// File: hw/rtl/tgwl_ram.sv
module tgwl_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tgwl_checker.sv
`include "torus_grid_wavefront_labeler_assert.svh"

module tgwl_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             out_valid,
  input tgwl_pkg::status_t                out_status,
  input logic                             out_found,
  input logic [tgwl_pkg::OUT_LABEL_W-1:0] out_label,
  input logic                             out_last
);

  import tgwl_pkg::*;

  // results before the final one of an item only come while busy
  `TGWL_ASSERT_SAME(a_mid_result_busy, out_valid && !out_last, busy, "non-final item result while idle")

  // a result naming no neighbour always closes its item
  `TGWL_ASSERT_SAME(a_notfound_last, out_valid && !out_found, out_last, "not-found result is not last")

  // out-of-range cells never report a neighbour or a label
  `TGWL_ASSERT_SAME(a_range_empty, out_valid && (out_status == ST_RANGE), !out_found && (out_label == '0), "out-of-range result carries data")

  // an accepted item either answers at once or holds busy
  `TGWL_ASSERT_NEXT(a_accept_progress, start && !busy, busy || out_valid, "accepted item made no progress")

endmodule

bind torus_grid_wavefront_labeler tgwl_checker u_tgwl_checker (.*);

// File: bench/torus_grid_wavefront_labeler_test.sv
`timescale 1ns / 100ps

// Bench for the wrapping-grid wavefront labeler.
// Commands go in one item at a time on start/busy; results come back with
// no backpressure, so every out_valid cycle is checked against the oldest
// prediction held by the scoreboard.
module torus_grid_wavefront_labeler_test;
  import tgwl_pkg::*;

  localparam int GRID  = 64;
  localparam int CELLS = GRID * GRID;
  localparam logic [OUT_LABEL_W-1:0] LABEL_TOP = '1;
  // op codes above OP_PRED are undefined; this is the top of the 3-bit field
  localparam op_t OP_MAX_CODE = 3'd7;
  // slack after the last predicted result; covers the longest item from accept to last result
  localparam int DRAIN_CYCLES = 12;

  typedef struct {
    status_t                status;
    logic                   found;
    logic [COORD_W-1:0]     nx;
    logic [COORD_W-1:0]     ny;
    logic [OUT_LABEL_W-1:0] label;
    logic                   is_last;
  } cell_result_t;

  // Mirror of the cell stores and edges; turns each accepted item into the
  // results it should cause and checks results as they come out.
  class grid_scoreboard;
    bit                     blocked   [CELLS];
    logic [OUT_LABEL_W-1:0] label_map [CELLS];
    logic [COORD_W-1:0]     edge_x;
    logic [COORD_W-1:0]     edge_y;
    cell_result_t           result_q [$];
    int                     errors;

    function new();
      foreach (blocked[i]) begin
        blocked[i]   = 1'b0;
        label_map[i] = '0;
      end
      edge_x = 6'd63;
      edge_y = 6'd63;
      errors = 0;
    endfunction

    function void note_cfg(cfg_idx_t idx, logic [CFG_W-1:0] v);
      if (idx == CFG_EDGE_X) edge_x = v;
      else edge_y = v;
    endfunction

    function int pending();
      return result_q.size();
    endfunction

    function int cell_of(logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy);
      return int'(cx) * GRID + int'(cy);
    endfunction

    function void add_result(status_t st, logic fnd, logic [COORD_W-1:0] nx,
                             logic [COORD_W-1:0] ny, logic [OUT_LABEL_W-1:0] lbl,
                             logic lst);
      cell_result_t r;
      r.status  = st;
      r.found   = fnd;
      r.nx      = nx;
      r.ny      = ny;
      r.label   = lbl;
      r.is_last = lst;
      result_q  = {result_q, r};
    endfunction

    function void note_item(op_t op, logic [IN_COORD_W-1:0] xr,
                            logic [IN_COORD_W-1:0] yr, logic [WV_W-1:0] wv);
      int                     sx, sy, ci, ni, cnt, k;
      bit                     inr;
      logic [COORD_W-1:0]     cx, cy;
      status_t                st;
      logic [OUT_LABEL_W-1:0] centre, newval;
      logic [COORD_W-1:0]     nxs [4];
      logic [COORD_W-1:0]     nys [4];
      bit   [3:0]             hit;
      sx  = $signed(xr);
      sy  = $signed(yr);
      inr = (sx >= 0) && (sy >= 0) && (sx <= int'(edge_x)) && (sy <= int'(edge_y));
      cx  = inr ? sx[COORD_W-1:0] : '0;
      cy  = inr ? sy[COORD_W-1:0] : '0;
      ci  = cell_of(cx, cy);
      st  = !inr ? ST_RANGE : (blocked[ci] ? ST_OCCUPIED : ST_OK);

      if (op > OP_PRED) begin
        add_result(ST_OK, 1'b0, '0, '0, '0, 1'b1);
        return;
      end
      if (!inr) begin
        add_result(ST_RANGE, 1'b0, '0, '0, '0, 1'b1);
        return;
      end
      if (op <= OP_CHECK) begin
        if (op == OP_BLOCK) blocked[ci] = 1'b1;
        else if (op == OP_WRITE) label_map[ci] = wv;
        add_result(st, 1'b0, '0, '0, label_map[ci], 1'b1);
        return;
      end

      centre = label_map[ci];
      newval = (centre == LABEL_TOP) ? LABEL_TOP : centre + 1'b1;
      nxs[DIR_E] = (cx == edge_x) ? '0 : cx + 1'b1;  nys[DIR_E] = cy;
      nxs[DIR_S] = cx;  nys[DIR_S] = (cy == 0) ? edge_y : cy - 1'b1;
      nxs[DIR_W] = (cx == 0) ? edge_x : cx - 1'b1;   nys[DIR_W] = cy;
      nxs[DIR_N] = cx;  nys[DIR_N] = (cy == edge_y) ? '0 : cy + 1'b1;

      // judge all four directions against the old contents first
      cnt = 0;
      for (int d = 0; d < 4; d++) begin
        ni = cell_of(nxs[d], nys[d]);
        if (op == OP_EXPAND) hit[d] = !blocked[ni] && (label_map[ni] == 0);
        else hit[d] = !blocked[ni] && (centre != 0) && (label_map[ni] == centre - 1'b1);
        cnt += hit[d];
      end
      if (cnt == 0) begin
        add_result(st, 1'b0, '0, '0, '0, 1'b1);
        return;
      end
      if (op == OP_EXPAND)
        for (int d = 0; d < 4; d++)
          if (hit[d]) label_map[cell_of(nxs[d], nys[d])] = newval;
      k = 0;
      for (int d = 0; d < 4; d++) begin
        if (hit[d]) begin
          k++;
          add_result(st, 1'b1, nxs[d], nys[d], label_map[cell_of(nxs[d], nys[d])],
                     k == cnt);
        end
      end
    endfunction

    function void check_result(status_t st, logic fnd, logic [COORD_W-1:0] nx,
                               logic [COORD_W-1:0] ny, logic [OUT_LABEL_W-1:0] lbl,
                               logic lst);
      cell_result_t e;
      if (result_q.size() == 0) begin
        $error("unexpected result: status %0d found %0b nx %0d ny %0d label %0d last %0b",
               st, fnd, nx, ny, lbl, lst);
        errors++;
        return;
      end
      e = result_q.pop_front();
      if (st !== e.status) begin
        $error("status mismatch: expected %0d, got %0d", e.status, st);
        errors++;
      end
      if (fnd !== e.found) begin
        $error("found mismatch: expected %0b, got %0b", e.found, fnd);
        errors++;
      end
      if (nx !== e.nx) begin
        $error("nx mismatch: expected %0d, got %0d", e.nx, nx);
        errors++;
      end
      if (ny !== e.ny) begin
        $error("ny mismatch: expected %0d, got %0d", e.ny, ny);
        errors++;
      end
      if (lbl !== e.label) begin
        $error("label mismatch: expected %0d, got %0d", e.label, lbl);
        errors++;
      end
      if (lst !== e.is_last) begin
        $error("last mismatch: expected %0b, got %0b", e.is_last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  op_t                           in_op;
  logic signed [IN_COORD_W-1:0]  in_x;
  logic signed [IN_COORD_W-1:0]  in_y;
  logic [WV_W-1:0]               in_write_value;
  logic                          out_valid;
  status_t                       out_status;
  logic                          out_found;
  logic [COORD_W-1:0]            out_nx;
  logic [COORD_W-1:0]            out_ny;
  logic [OUT_LABEL_W-1:0]        out_label;
  logic                          out_last;
  logic                          cfg_we;
  cfg_idx_t                      cfg_index;
  logic [CFG_W-1:0]              cfg_data;

  grid_scoreboard sb = new();

  // edges the driver believes are in force; used to aim items at real cells
  int cur_ex = 63;
  int cur_ey = 63;
  bit allow_idle;
  int items_sent;

  // edge settings per random phase: 1x1, 2x2, thin strips, odd shapes,
  // full size, 4x4; the last phase (4x4) runs with no idling at all
  int edge_x_plan [9] = '{0, 1, 0, 63, 2, 5, 63, 1, 3};
  int edge_y_plan [9] = '{0, 1, 63, 0, 3, 7, 63, 0, 3};

  torus_grid_wavefront_labeler uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_x           (in_x),
    .in_y           (in_y),
    .in_write_value (in_write_value),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_found      (out_found),
    .out_nx         (out_nx),
    .out_ny         (out_ny),
    .out_label      (out_label),
    .out_last       (out_last),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always #5 clk = ~clk;

  // Monitor. Inputs move on the falling edge, so everything sampled here is
  // stable. A result seen in the same cycle an item is taken always belongs
  // to an older item, so checking before noting is safe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid)
        sb.check_result(out_status, out_found, out_nx, out_ny, out_label, out_last);
      if (start && !busy)
        sb.note_item(in_op, in_x, in_y, in_write_value);
      if (cfg_we)
        sb.note_cfg(cfg_index, cfg_data);
    end
  end

  // wrapped neighbour coordinates under the current edges
  function automatic int nb_x(int cx, dir_t d);
    case (d)
      DIR_E:   return (cx == cur_ex) ? 0 : cx + 1;
      DIR_W:   return (cx == 0) ? cur_ex : cx - 1;
      default: return cx;
    endcase
  endfunction

  function automatic int nb_y(int cy, dir_t d);
    case (d)
      DIR_S:   return (cy == 0) ? cur_ey : cy - 1;
      DIR_N:   return (cy == cur_ey) ? 0 : cy + 1;
      default: return cy;
    endcase
  endfunction

  // Present one item at a falling edge and hold it until taken. start is
  // left high on return so a following item goes out with no gap; an idle
  // burst, when drawn, lowers it first.
  task automatic send_item(input op_t op, input int x, input int y, input int wv);
    in_op          <= op;
    in_x           <= x[IN_COORD_W-1:0];
    in_y           <= y[IN_COORD_W-1:0];
    in_write_value <= wv[WV_W-1:0];
    start          <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    @(negedge clk);
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
  endtask

  // stop sending, let all predicted results come out, then some slack
  task automatic settle();
    start <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic load_edges(input int ex, input int ey);
    cur_ex    = ex;
    cur_ey    = ey;
    cfg_we    <= 1'b1;
    cfg_index <= CFG_EDGE_X;
    cfg_data  <= ex[CFG_W-1:0];
    @(negedge clk);
    cfg_index <= CFG_EDGE_Y;
    cfg_data  <= ey[CFG_W-1:0];
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Seed a label, grow the wave one ring out, then walk back with
  // predecessor lookups. Some steps are dropped or a neighbour is walled
  // off so the sequence is not always clean.
  task automatic wave_burst();
    int   sx, sy, px, py, v;
    dir_t d;
    sx = $urandom_range(0, cur_ex);
    sy = $urandom_range(0, cur_ey);
    case ($urandom_range(0, 6))
      0:       v = LABEL_TOP;
      1:       v = LABEL_TOP - 1;
      2:       v = $urandom_range(0, 65535);
      3:       v = 0;
      default: v = $urandom_range(1, 5);
    endcase
    if ($urandom_range(0, 4) != 0) send_item(OP_WRITE, sx, sy, v);
    if ($urandom_range(0, 4) == 0) begin
      d = dir_t'($urandom_range(0, 3));
      send_item(OP_BLOCK, nb_x(sx, d), nb_y(sy, d), $urandom_range(0, 65535));
    end
    send_item(OP_EXPAND, sx, sy, $urandom_range(0, 65535));
    for (int i = 0; i < 4; i++)
      if ($urandom_range(0, 3) != 0)
        send_item(OP_EXPAND, nb_x(sx, dir_t'(i)), nb_y(sy, dir_t'(i)),
                  $urandom_range(0, 65535));
    d  = dir_t'($urandom_range(0, 3));
    px = nb_x(sx, d);
    py = nb_y(sy, d);
    send_item(OP_PRED, px, py, $urandom_range(0, 65535));
    if ($urandom_range(0, 2) == 0)
      send_item(OP_PRED, nb_x(px, d), nb_y(py, d), $urandom_range(0, 65535));
    if ($urandom_range(0, 3) == 0)
      send_item(OP_CHECK, px, py, $urandom_range(0, 65535));
  endtask

  // single item of any op, including undefined codes, often off the grid
  task automatic noise_item();
    int  r, x, y;
    op_t op;
    r = $urandom_range(0, 19);
    if (r < 3) op = OP_BLOCK;
    else if (r < 6) op = OP_WRITE;
    else if (r < 9) op = OP_CHECK;
    else if (r < 13) op = OP_EXPAND;
    else if (r < 16) op = OP_PRED;
    else op = op_t'($urandom_range(int'(OP_PRED) + 1, int'(OP_MAX_CODE)));
    case ($urandom_range(0, 3))
      0, 1: begin
        x = $urandom_range(0, cur_ex);
        y = $urandom_range(0, cur_ey);
      end
      2: begin
        // past the x edge, or negative
        x = $urandom_range(cur_ex + 1, 255);
        y = $urandom_range(0, 255);
      end
      default: begin
        x = $urandom_range(0, cur_ex);
        y = $urandom_range(cur_ey + 1, 255);
      end
    endcase
    send_item(op, x, y, $urandom_range(0, 65535));
  endtask

  task automatic run_phase(input int count);
    int stop_at;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 9) < 7) wave_burst();
      else noise_item();
    end
  endtask

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    start          = 1'b0;
    in_op          = OP_BLOCK;
    in_x           = '0;
    in_y           = '0;
    in_write_value = '0;
    cfg_we         = 1'b0;
    cfg_index      = CFG_EDGE_X;
    cfg_data       = '0;
    allow_idle     = 1'b1;
    items_sent     = 0;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    // clearing pass holds busy high
    @(negedge clk);
    while (busy) @(negedge clk);

    // Directed items on the full 64x64 grid at reset edges.
    send_item(OP_CHECK, 0, 0, 16'hFFFF);
    // saturation at the top label, with the east and north neighbours wrapping
    send_item(OP_WRITE, 63, 63, 16'hFFFF);
    send_item(OP_EXPAND, 63, 63, 0);
    send_item(OP_WRITE, 10, 10, 16'hFFFE);
    send_item(OP_EXPAND, 10, 10, 16'h5A5A);
    // neighbours all labelled now: nothing qualifies
    send_item(OP_EXPAND, 10, 10, 0);
    send_item(OP_PRED, 11, 10, 0);
    // blocked centre: status occupied, expand still runs
    send_item(OP_BLOCK, 5, 5, 16'hFFFF);
    send_item(OP_CHECK, 5, 5, 0);
    send_item(OP_BLOCK, 5, 5, 0);
    send_item(OP_EXPAND, 5, 5, 0);
    send_item(OP_PRED, 5, 6, 0);
    // unlabelled centre never has predecessors
    send_item(OP_PRED, 20, 20, 0);
    send_item(OP_WRITE, 63, 63, 0);
    // off-grid cells in every direction
    send_item(OP_CHECK, -1, 0, 0);
    send_item(OP_WRITE, 64, 3, 16'h1234);
    send_item(OP_EXPAND, 3, -128, 0);
    send_item(OP_PRED, 127, 127, 0);
    send_item(OP_BLOCK, -128, -1, 0);
    for (int c = int'(OP_PRED) + 1; c <= int'(OP_MAX_CODE); c++)
      send_item(op_t'(c), 1, 2, 16'hBEEF);

    // Random phases; edges only change once the block has drained.
    for (int p = 0; p < 9; p++) begin
      settle();
      allow_idle = (p != 8);
      load_edges(edge_x_plan[p], edge_y_plan[p]);
      run_phase(40);
    end
    settle();

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("torus_grid_wavefront_labeler verification clean");
    end else begin
      $display("torus_grid_wavefront_labeler verification failed");
    end
    $finish;
  end

  // watchdog: well past the clearing pass plus the slowest legal run
  initial begin
    #3000000;
    $display("torus_grid_wavefront_labeler verification failed");
    $finish;
  end

endmodule
